// ----- design/gals_pkg.sv -----
`timescale 1ns / 1ps

package gals_pkg;

  // Pointer width of a head or link word and the mark that ends a chain.
  localparam int unsigned PTR_W = 7;
  localparam logic [PTR_W-1:0] EMPTY_MARK = 7'd127;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LIST   = 2'd1;
  localparam logic [1:0] FUNC_DEGREE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] source_vertex;
    logic [5:0] target_vertex;
  } req_t;

  typedef struct packed {
    logic [5:0] neighbour;
    logic [6:0] count;
    logic       last;
    logic [1:0] status;
  } res_t;

  // One slot of the edge pool.
  typedef struct packed {
    logic [5:0]       target;
    logic [PTR_W-1:0] link;
  } edge_t;

endpackage

// ----- design/gals_ram.sv -----
`timescale 1ns / 1ps

module gals_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/graph_adjacency_list_store.sv -----
`timescale 1ns / 1ps

// Directed graph store in forward-star form. Each vertex has a head word in a
// head memory that points at its newest outgoing edge, and a pool of edge slots
// in a second memory holds each edge's target and a link to the next older edge
// of the same source. A word is accepted when start_i is high and busy_o is low.
// An insert prepends an edge and returns the new edge total, or flags the pool
// full. A list walks the chain and returns one word per neighbour, newest first,
// with a running count and last set on the final one; an empty chain returns one
// word flagged empty. A degree query walks the chain and returns only the count.
// Results appear on res_o for exactly one cycle, marked by res_valid_o, and the
// receiver cannot hold them off. After reset the block sweeps the head memory,
// one entry per cycle, and busy_o stays high until the sweep is done. An insert
// holds busy_o high while it writes (the head is read at the accepting edge,
// both writes follow in the next cycle); a list or degree query holds busy_o
// high until its walk ends, since the walk follows links through the edge
// memory's registered read port. Neither takes a new word before it is done.
// A word that causes no result, or one answered without a memory access, lets
// the next word in on the following cycle.
module graph_adjacency_list_store #(
  parameter int NUM_VERTICES = 64,
  parameter int MAX_EDGES    = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gals_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output gals_pkg::res_t res_o
);

  import gals_pkg::*;

  localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [PTR_W-1:0] MAX_PTR = PTR_W'(MAX_EDGES);
  localparam logic [VW-1:0] LAST_VTX = VW'(NUM_VERTICES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_HEAD,
    S_WALK
  } state_e;

  state_e           state_q;
  logic [VW-1:0]    clr_q;
  logic [1:0]       func_q;
  logic [5:0]       src_q;
  logic [5:0]       tgt_q;
  logic [6:0]       used_q;
  logic [6:0]       n_q;
  logic             res_valid_q;
  res_t             res_q;

  logic             head_we;
  logic [VW-1:0]    head_waddr;
  logic [PTR_W-1:0] head_wdata;
  logic [VW-1:0]    head_raddr;
  logic [PTR_W-1:0] head_rdata;

  logic             edge_we;
  logic [EW-1:0]    edge_waddr;
  edge_t            edge_wdata;
  logic [EW-1:0]    edge_raddr;
  edge_t            edge_rdata;

  logic             accept;
  logic             src_ok;
  logic [6:0]       n_inc;
  logic             walk_fin;

  assign accept   = start_i && (state_q == S_IDLE);
  assign src_ok   = int'(req_i.source_vertex) < NUM_VERTICES;
  assign n_inc    = n_q + 7'd1;
  // The chain ends on a link that names no slot, or once the pool size is reached.
  assign walk_fin = (edge_rdata.link >= MAX_PTR) || (n_inc >= 7'(MAX_EDGES));

  // The head is read on every cycle at the offered vertex, so its word is ready
  // in the cycle after a query or insert is accepted.
  assign head_raddr = VW'(req_i.source_vertex);

  always_comb begin
    head_we    = 1'b0;
    head_waddr = clr_q;
    head_wdata = EMPTY_MARK;
    edge_we    = 1'b0;
    edge_waddr = EW'(used_q);
    edge_wdata = '{target: tgt_q, link: head_rdata};
    edge_raddr = EW'(edge_rdata.link);
    unique case (state_q)
      S_CLEAR: begin
        head_we = 1'b1;
      end
      S_INS: begin
        // New slot takes the old head as its link and becomes the head.
        head_we    = 1'b1;
        head_waddr = VW'(src_q);
        head_wdata = used_q;
        edge_we    = 1'b1;
      end
      S_HEAD: begin
        edge_raddr = EW'(head_rdata);
      end
      default: begin
      end
    endcase
  end

  gals_ram #(
    .WIDTH(PTR_W),
    .DEPTH(NUM_VERTICES)
  ) u_head_ram (
    .clk_i  (clk_i),
    .we_i   (head_we),
    .waddr_i(head_waddr),
    .wdata_i(head_wdata),
    .raddr_i(head_raddr),
    .rdata_o(head_rdata)
  );

  gals_ram #(
    .WIDTH($bits(edge_t)),
    .DEPTH(MAX_EDGES)
  ) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edge_we),
    .waddr_i(edge_waddr),
    .wdata_i(edge_wdata),
    .raddr_i(edge_raddr),
    .rdata_o(edge_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      func_q      <= FUNC_INSERT;
      src_q       <= '0;
      tgt_q       <= '0;
      used_q      <= '0;
      n_q         <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + VW'(1);
          if (clr_q == LAST_VTX) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            func_q <= req_i.func;
            src_q  <= req_i.source_vertex;
            tgt_q  <= req_i.target_vertex;
            n_q    <= '0;
            case (req_i.func) inside
              FUNC_INSERT: begin
                if (used_q >= 7'(MAX_EDGES)) begin
                  res_valid_q <= 1'b1;
                  res_q       <= '{neighbour: '0, count: used_q, last: 1'b1,
                                   status: STATUS_FULL};
                end else if (!src_ok) begin
                  res_valid_q <= 1'b1;
                  res_q       <= '{neighbour: '0, count: used_q, last: 1'b1,
                                   status: STATUS_OK};
                end else begin
                  state_q <= S_INS;
                end
              end
              FUNC_LIST, FUNC_DEGREE: begin
                if (!src_ok) begin
                  res_valid_q <= 1'b1;
                  res_q       <= '{neighbour: '0, count: '0, last: 1'b1,
                                   status: (req_i.func == FUNC_LIST) ?
                                           STATUS_EMPTY : STATUS_OK};
                end else begin
                  state_q <= S_HEAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS: begin
          used_q      <= used_q + 7'd1;
          res_valid_q <= 1'b1;
          res_q       <= '{neighbour: '0, count: used_q + 7'd1, last: 1'b1,
                           status: STATUS_OK};
          state_q     <= S_IDLE;
        end
        S_HEAD: begin
          if (head_rdata >= MAX_PTR) begin
            res_valid_q <= 1'b1;
            res_q       <= '{neighbour: '0, count: '0, last: 1'b1,
                             status: (func_q == FUNC_LIST) ? STATUS_EMPTY : STATUS_OK};
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_WALK;
          end
        end
        S_WALK: begin
          n_q <= n_inc;
          if (func_q == FUNC_LIST) begin
            res_valid_q <= 1'b1;
            res_q       <= '{neighbour: edge_rdata.target, count: n_inc,
                             last: walk_fin, status: STATUS_OK};
          end else if (walk_fin) begin
            res_valid_q <= 1'b1;
            res_q       <= '{neighbour: '0, count: n_inc, last: 1'b1,
                             status: STATUS_OK};
          end
          if (walk_fin) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- design/gals_checker.sv -----
`timescale 1ns / 1ps

module gals_checker #(
  parameter int MAX_EDGES = 64
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input gals_pkg::req_t req_i,
  input logic           busy_o,
  input logic           res_valid_o,
  input gals_pkg::res_t res_o
);

  import gals_pkg::*;

  // An accepted insert either answers at once or starts its memory access.
  a_insert_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.func == FUNC_INSERT) |=> res_valid_o || busy_o)
    else $error("insert neither answered nor started");

  // The final word of an item leaves the block free.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy_o)
    else $error("block still busy after final word");

  // A list walk delivers its words on consecutive cycles.
  a_walk_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o && (res_o.count == $past(res_o.count) + 7'd1))
    else $error("list walk word missing or count skipped");

  // A full pool reports its size, alone and without a neighbour.
  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == STATUS_FULL) |->
      res_o.last && (res_o.neighbour == 6'd0) && (res_o.count == 7'(MAX_EDGES)))
    else $error("malformed pool full word");

endmodule

bind graph_adjacency_list_store gals_checker #(
  .MAX_EDGES(MAX_EDGES)
) u_gals_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .req_i      (req_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the forward-star graph store. A driver presents command words
// from a queue that the stimulus block fills, a monitor predicts the answer
// words of every accepted command and checks each answer word field by field,
// and a watchdog ends the run if the block stops making progress.
module tb;
  import gals_pkg::*;

  localparam int NUM_VERTICES = 64;
  localparam int MAX_EDGES    = 64;

  // The fourth function code is not used by the block; it must be swallowed
  // without any answer word.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Cycles without any accepted command or answer word before we give up.
  // The longest legal quiet stretch is the reset time plus the head sweep, or
  // a degree query on a chain that fills the whole pool followed by the
  // longest sender gap, so this is generous.
  localparam int QUIET_LIMIT = 1000;

  // Settling time after the last answer: a full chain walk plus overhead.
  localparam int TAIL_CYCLES = 2 * MAX_EDGES + 8;

  // One command word waiting to be sent, with the idle cycles that follow it.
  typedef struct {
    req_t        w;
    int unsigned gap;
  } cmd_slot_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i   = '0;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  graph_adjacency_list_store #(
    .NUM_VERTICES(NUM_VERTICES),
    .MAX_EDGES   (MAX_EDGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Command words not yet presented to the block.
  cmd_slot_t pending_cmds_q[$];

  // Answer words the graph store owes us, oldest first.
  res_t graph_answers_q[$];

  // Our own copy of the graph: head pointer per vertex, the edge pool, and
  // the number of pool slots in use.
  logic [6:0] head_ptr[NUM_VERTICES];
  logic [5:0] pool_target[MAX_EDGES];
  logic [6:0] pool_link[MAX_EDGES];
  logic [6:0] edge_total;

  int mismatches;
  int quiet_cycles;
  int idle_left;

  initial begin
    for (int v = 0; v < NUM_VERTICES; v++) begin
      head_ptr[v] = EMPTY_MARK;
    end
    edge_total  = '0;
    mismatches  = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Applies one accepted command word to our copy of the graph and queues the
  // answer words that the block must return for it. An insert either links a
  // new edge in front of the source's chain or, with the pool exhausted,
  // reports full. A list walks the chain newest first and marks the final
  // neighbour; a chain that ends at once yields a single empty-flagged word.
  // A degree query walks the same chain but answers with the count alone.
  task automatic graph_answer(input req_t w);
    res_t       r;
    logic [6:0] p;
    logic [6:0] nx;
    int         n;
    r      = '0;
    r.last = 1'b1;
    p      = EMPTY_MARK;
    if (int'(w.source_vertex) < NUM_VERTICES) p = head_ptr[w.source_vertex];
    case (w.func)
      FUNC_INSERT: begin
        if (int'(edge_total) >= MAX_EDGES) begin
          r.status = STATUS_FULL;
        end else begin
          r.status = STATUS_OK;
          if (int'(w.source_vertex) < NUM_VERTICES) begin
            pool_target[edge_total]  = w.target_vertex;
            pool_link[edge_total]    = head_ptr[w.source_vertex];
            head_ptr[w.source_vertex] = edge_total;
            edge_total++;
          end
        end
        r.count = edge_total;
        graph_answers_q.push_back(r);
      end
      FUNC_LIST: begin
        n = 0;
        while (int'(p) < MAX_EDGES && n < MAX_EDGES) begin
          nx          = pool_link[p];
          r.neighbour = pool_target[p];
          r.count     = 7'(n + 1);
          r.last      = !(int'(nx) < MAX_EDGES) || (n + 1 >= MAX_EDGES);
          r.status    = STATUS_OK;
          graph_answers_q.push_back(r);
          n++;
          p = nx;
        end
        if (n == 0) begin
          r        = '0;
          r.last   = 1'b1;
          r.status = STATUS_EMPTY;
          graph_answers_q.push_back(r);
        end
      end
      FUNC_DEGREE: begin
        n = 0;
        while (int'(p) < MAX_EDGES && n < MAX_EDGES) begin
          p = pool_link[p];
          n++;
        end
        r.count  = 7'(n);
        r.status = STATUS_OK;
        graph_answers_q.push_back(r);
      end
      default: begin
        // Unused code: no state change and no answer word.
      end
    endcase
  endtask

  // Driver. A command word stays on req_i with start_i high until the block
  // takes it (start_i high while busy_o is low at a rising edge). Once taken,
  // or while nothing is offered, the driver burns the idle cycles drawn for
  // the previous word and then offers the next one. Idle cycles count down
  // whether or not the block is busy, so gaps land on every phase of its work.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i   <= 1'b0;
      req_i     <= '0;
      idle_left <= 0;
    end else if (!start_i || !busy_o) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start_i   <= 1'b0;
      end else if (pending_cmds_q.size() != 0) begin
        req_i     <= pending_cmds_q[0].w;
        idle_left <= pending_cmds_q[0].gap;
        start_i   <= 1'b1;
        void'(pending_cmds_q.pop_front());
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor. Both the command handshake and the answer strobe are sampled at
  // the same rising edge, so the prediction of a word taken at this edge is
  // queued before any answer word can be compared against it.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) graph_answer(req_i);
      if (res_valid_o) begin
        if (graph_answers_q.size() == 0) begin
          flag_mismatch($sformatf("answer word with none expected: nb %0d cnt %0d last %0b st %0d",
                                  res_o.neighbour, res_o.count, res_o.last, res_o.status));
        end else begin
          want = graph_answers_q.pop_front();
          if (res_o.neighbour !== want.neighbour)
            flag_mismatch($sformatf("neighbour %0d, expected %0d", res_o.neighbour,
                                    want.neighbour));
          if (res_o.count !== want.count)
            flag_mismatch($sformatf("count %0d, expected %0d", res_o.count, want.count));
          if (res_o.last !== want.last)
            flag_mismatch($sformatf("last %0b, expected %0b", res_o.last, want.last));
          if (res_o.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", res_o.status, want.status));
        end
      end
    end
  end

  // Watchdog. Any accepted command or answer word counts as progress; a hung
  // walk or a lost answer word stalls both and trips the limit.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Queues one command word. In a burst the word is followed by no idle
  // cycles at all; otherwise the idle gap after it is drawn at random.
  task automatic queue_cmd(input logic [1:0] f, input logic [5:0] src,
                           input logic [5:0] tgt, input bit burst);
    cmd_slot_t s;
    s.w.func          = f;
    s.w.source_vertex = src;
    s.w.target_vertex = tgt;
    s.gap             = burst ? 0 : $urandom_range(0, 6);
    pending_cmds_q.push_back(s);
  endtask

  // Holds the sender back until every queued word has gone out and every
  // answer word it caused has come back. Sampled on the falling edge, where
  // everything from the preceding rising edge has settled.
  task automatic drain_answers();
    while (pending_cmds_q.size() != 0 || start_i || graph_answers_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    logic [5:0] hot[3];
    logic [1:0] f;
    logic [5:0] src;
    int unsigned sel;
    bit burst;

    quiet_cycles = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words. Queries on an empty graph first: a zero degree and an
    // empty list. Then edges between the lowest and highest vertex numbers, a
    // list of each chain built, the degrees of the lowest and highest vertex,
    // and the unused function code with all-zero and all-one fields.
    queue_cmd(FUNC_DEGREE, 6'd0,  6'($urandom_range(0, 63)), 1'b0);
    queue_cmd(FUNC_LIST,   6'd63, 6'($urandom_range(0, 63)), 1'b0);
    queue_cmd(FUNC_UNUSED, 6'd63, 6'd63, 1'b0);
    queue_cmd(FUNC_INSERT, 6'd0,  6'd63, 1'b0);
    queue_cmd(FUNC_INSERT, 6'd0,  6'd0,  1'b1);
    queue_cmd(FUNC_INSERT, 6'd63, 6'd0,  1'b1);
    queue_cmd(FUNC_INSERT, 6'd63, 6'd63, 1'b0);
    queue_cmd(FUNC_INSERT, 6'd0,  6'd42, 1'b0);
    queue_cmd(FUNC_INSERT, 6'd21, 6'd21, 1'b0);
    queue_cmd(FUNC_LIST,   6'd0,  6'd63, 1'b0);
    queue_cmd(FUNC_LIST,   6'd63, 6'd0,  1'b1);
    queue_cmd(FUNC_LIST,   6'd21, 6'($urandom_range(0, 63)), 1'b1);
    queue_cmd(FUNC_DEGREE, 6'd0,  6'd63, 1'b0);
    queue_cmd(FUNC_DEGREE, 6'd63, 6'd0,  1'b0);
    queue_cmd(FUNC_UNUSED, 6'd0,  6'd0,  1'b1);
    queue_cmd(FUNC_LIST,   6'd1,  6'($urandom_range(0, 63)), 1'b0);
    queue_cmd(FUNC_DEGREE, 6'd62, 6'($urandom_range(0, 63)), 1'b0);
    drain_answers();

    // Random words. Most edges go to three hot vertices so their chains grow
    // long and the lists come back as long runs of answer words; the rest
    // spread over all vertices. The pool fills within the first half, after
    // which inserts report full while the queries keep walking full chains.
    // Every third stretch of twenty words is sent back to back.
    for (int i = 0; i < 3; i++) hot[i] = 6'($urandom_range(0, 63));
    for (int k = 0; k < 310; k++) begin
      if (k == 150) drain_answers();
      burst = ((k / 20) % 3) == 2;
      sel   = $urandom_range(0, 99);
      if (sel < 50)      f = FUNC_INSERT;
      else if (sel < 80) f = FUNC_LIST;
      else if (sel < 96) f = FUNC_DEGREE;
      else               f = FUNC_UNUSED;
      if ($urandom_range(0, 2) == 0) src = 6'($urandom_range(0, 63));
      else                           src = hot[$urandom_range(0, 2)];
      queue_cmd(f, src, 6'($urandom_range(0, 63)), burst);
    end

    drain_answers();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
